>>> design/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared sizes, codes and controller/datapath interface types for the
// two-resource first-fit packing block.
// ----------------------------------------------------------------------------
package ffp_pkg;

	// Bin table geometry.
	localparam int MAX_BINS    = 64;
	localparam int NUM_CLASSES = 2;

	// Field widths.
	localparam int CLS_W     = 1;
	localparam int CPU_W     = 10;
	localparam int MEM_W     = 16;
	localparam int BIN_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CNT_W     = $clog2(MAX_BINS + 1);
	localparam int ENT_W     = CPU_W + MEM_W;
	localparam int ADDR_W    = CLS_W + BIN_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int CLS_SLOTS = 1 << CLS_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = MEM_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAP_CPU0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_MEM0 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_CPU1 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_MEM1 = 2'd3;

	// Request function codes.
	localparam logic FUNC_PLACE = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OPEN     = 3'd0,
		ST_NEW      = 3'd1,
		ST_OVERSIZE = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;     // latch the incoming request word
		logic    issue;    // read the next bin of the scan
		logic    hit_wr;   // charge the bin that matched
		logic    new_wr;   // open a new bin at the tail
		logic    clr;      // empty the class
		logic    respond;  // register a result word
		status_t code;
	} ffp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic class_bad;
		logic clear;
		logic oversize;
		logic issue_done;
		logic pending;
		logic hit;
		logic full;
	} ffp_stat_t;

endpackage

>>> design/first_fit_two_resource_packing_top.sv
// ----------------------------------------------------------------------------
// first_fit_two_resource_packing_top
// Two-resource first-fit bin packing engine with per-class bin rows.
// Usage: a request word (func, item_class, cpu_need, mem_need) is taken with
// start high at a rising edge where busy is low. A place request goes into the
// lowest open bin of its class with enough CPU and memory left, else a new bin
// is opened; a clear request empties the class. One result word (status,
// bin_index, bins_used) follows, marked by done for one cycle; no stall.
// A reject or clear is answered straight from the check state. A placement
// scans the open bins one per cycle through the registered bin memory read
// and stops at the first match; when no bin fits, a new bin is opened or
// the table is reported full. A new request is taken in the done cycle.
// Capacities are written through cfg_we/cfg_idx/cfg_data while busy is low.
// Reset clears the bin counts and loads the default capacities (CPU 64,
// memory 256); open bins keep their remainders on a capacity change, and the
// bin memory needs no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_two_resource_packing_top import ffp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [CLS_W-1:0]     item_class,
	input  logic [CPU_W-1:0]     cpu_need,
	input  logic [MEM_W-1:0]     mem_need,
	output logic                 done,
	output logic [2:0]           status,
	output logic [BIN_W-1:0]     bin_index,
	output logic [CNT_W-1:0]     bins_used
);

	ffp_cmd_t  cmd;
	ffp_stat_t stat;

	// Sequencer.
	ffp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Storage and arithmetic.
	ffp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.func       (func),
		.item_class (item_class),
		.cpu_need   (cpu_need),
		.mem_need   (mem_need),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.status     (status),
		.bin_index  (bin_index),
		.bins_used  (bins_used)
	);

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// A result word only ends a request that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a request in progress");

	// A newly opened bin is the last one of the class.
	a_new_bin_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NEW) |-> (bins_used == CNT_W'(bin_index) + CNT_W'(1)))
		else $error("new bin index does not match bin count");

	// Unplaced results carry bin index zero.
	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OPEN && status != ST_NEW) |-> (bin_index == '0))
		else $error("nonzero bin index on an unplaced result");

endmodule

>>> design/ffp_ctrl.sv
// ----------------------------------------------------------------------------
// ffp_ctrl
// Sequencer for one request: check, clear a class or scan open bins, then
// charge a bin, open a new one or report a reject.
// ----------------------------------------------------------------------------
module ffp_ctrl import ffp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ffp_stat_t stat,
	output ffp_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_SCAN  = 4'b0100,
		S_MISS  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.code    = ST_OPEN;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.class_bad) begin
					cmd.respond = 1'b1;
					cmd.code    = stat.clear ? ST_CLEARED : ST_FULL;
					state_d     = S_IDLE;
				end else if (stat.clear) begin
					cmd.clr     = 1'b1;
					cmd.respond = 1'b1;
					cmd.code    = ST_CLEARED;
					state_d     = S_IDLE;
				end else if (stat.oversize) begin
					cmd.respond = 1'b1;
					cmd.code    = ST_OVERSIZE;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// Reads go out one bin a cycle; a match stops the scan.
				if (stat.hit) begin
					cmd.hit_wr  = 1'b1;
					cmd.respond = 1'b1;
					cmd.code    = ST_OPEN;
					state_d     = S_IDLE;
				end else begin
					cmd.issue = !stat.issue_done;
					if (stat.issue_done && !stat.pending) begin
						state_d = S_MISS;
					end
				end
			end
			S_MISS: begin
				cmd.respond = 1'b1;
				if (stat.full) begin
					cmd.code = ST_FULL;
				end else begin
					cmd.new_wr = 1'b1;
					cmd.code   = ST_NEW;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> design/ffp_dp.sv
// ----------------------------------------------------------------------------
// ffp_dp
// Datapath: capacity registers, request word, per-class bin counts, the
// bin remainder memory with its scan pipeline, and the result registers.
// ----------------------------------------------------------------------------
module ffp_dp import ffp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 func,
	input  logic [CLS_W-1:0]     item_class,
	input  logic [CPU_W-1:0]     cpu_need,
	input  logic [MEM_W-1:0]     mem_need,
	input  ffp_cmd_t             cmd,
	output ffp_stat_t            stat,
	output logic                 done,
	output logic [2:0]           status,
	output logic [BIN_W-1:0]     bin_index,
	output logic [CNT_W-1:0]     bins_used
);

	logic [CPU_W-1:0] cap_cpu0_q, cap_cpu1_q;
	logic [MEM_W-1:0] cap_mem0_q, cap_mem1_q;
	logic             func_q;
	logic [CLS_W-1:0] cls_q;
	logic [CPU_W-1:0] cpu_q;
	logic [MEM_W-1:0] mem_q;
	logic [CNT_W-1:0] cnt_q [CLS_SLOTS];
	logic [CNT_W-1:0] rd_bin_q;
	logic             rdv_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [ENT_W-1:0] rd_s1;
	logic [ENT_W-1:0] rem_mem [MEM_DEPTH];

	logic [CPU_W-1:0]  cap_cpu_sel;
	logic [MEM_W-1:0]  cap_mem_sel;
	logic [CNT_W-1:0]  count_cur;
	logic [CPU_W-1:0]  rd_cpu;
	logic [MEM_W-1:0]  rd_mem;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [ADDR_W-1:0] rd_addr;

	// Capacity registers: the user writes them only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cpu0_q <= CPU_W'(64);
			cap_mem0_q <= MEM_W'(256);
			cap_cpu1_q <= CPU_W'(64);
			cap_mem1_q <= MEM_W'(256);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CAP_CPU0: cap_cpu0_q <= cfg_data[CPU_W-1:0];
				REG_CAP_MEM0: cap_mem0_q <= cfg_data[MEM_W-1:0];
				REG_CAP_CPU1: cap_cpu1_q <= cfg_data[CPU_W-1:0];
				REG_CAP_MEM1: cap_mem1_q <= cfg_data[MEM_W-1:0];
				default: ;
			endcase
		end
	end

	// Request word, held for the whole request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cls_q  <= item_class;
			cpu_q  <= cpu_need;
			mem_q  <= mem_need;
		end
	end

	assign cap_cpu_sel = (cls_q == CLS_W'(0)) ? cap_cpu0_q : cap_cpu1_q;
	assign cap_mem_sel = (cls_q == CLS_W'(0)) ? cap_mem0_q : cap_mem1_q;
	assign count_cur   = cnt_q[cls_q];
	assign rd_cpu      = rd_s1[ENT_W-1:MEM_W];
	assign rd_mem      = rd_s1[MEM_W-1:0];

	// Open bin count per class.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLS_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			cnt_q[cls_q] <= '0;
		end else if (cmd.new_wr) begin
			cnt_q[cls_q] <= count_cur + CNT_W'(1);
		end
	end

	// Scan address counter and read-valid pipeline bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_bin_q <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			rdv_s1 <= cmd.issue;
			if (cmd.load) begin
				rd_bin_q <= '0;
			end else if (cmd.issue) begin
				rd_bin_q <= rd_bin_q + CNT_W'(1);
			end
		end
	end

	// Write port: charge a matched bin or fill a newly opened one.
	assign wr_en   = cmd.hit_wr || cmd.new_wr;
	assign wr_addr = cmd.new_wr ? {cls_q, count_cur[BIN_W-1:0]} : {cls_q, bin_s1};
	assign wr_data = cmd.new_wr ? {cap_cpu_sel - cpu_q, cap_mem_sel - mem_q}
	                            : {rd_cpu - cpu_q, rd_mem - mem_q};
	assign rd_addr = {cls_q, rd_bin_q[BIN_W-1:0]};

	// Bin remainder memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rem_mem[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rd_s1  <= rem_mem[rd_addr];
			bin_s1 <= rd_bin_q[BIN_W-1:0];
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.class_bad  = (32'(cls_q) >= NUM_CLASSES);
		stat.clear      = (func_q == FUNC_CLEAR);
		stat.oversize   = (cpu_q > cap_cpu_sel) || (mem_q > cap_mem_sel);
		stat.issue_done = (rd_bin_q == count_cur);
		stat.pending    = rdv_s1;
		stat.hit        = rdv_s1 && (rd_cpu >= cpu_q) && (rd_mem >= mem_q);
		stat.full       = (count_cur == CNT_W'(MAX_BINS));
	end

	// Result registers: each word is shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status <= cmd.code;
			case (cmd.code)
				ST_OPEN: bin_index <= bin_s1;
				ST_NEW:  bin_index <= count_cur[BIN_W-1:0];
				default: bin_index <= '0;
			endcase
			if (stat.class_bad || cmd.code == ST_CLEARED) begin
				bins_used <= '0;
			end else if (cmd.code == ST_NEW) begin
				bins_used <= count_cur + CNT_W'(1);
			end else begin
				bins_used <= count_cur;
			end
		end
	end

endmodule

>>> tb/tb_first_fit_two_resource_packing_top.sv
// ----------------------------------------------------------------------------
// tb_first_fit_two_resource_packing_top
// Self-checking bench for the two-resource first-fit packing block.
//
// Request words go in through the start/busy handshake. A shadow bin table
// predicts the result word of each accepted request, and a checker compares
// every done word field by field with the oldest prediction. Directed
// requests cover the corner cases first: zero demand, exact fit, oversize,
// clear, capacity change with open bins and a full table. Random phases then
// follow, with varied capacities and sender idling.
// ----------------------------------------------------------------------------
module tb_first_fit_two_resource_packing_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffp_pkg::*;

	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		status_t          status;
		logic [BIN_W-1:0] bin;
		logic [CNT_W-1:0] used;
	} pack_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx    = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;
	logic                 start      = 1'b0;
	logic                 func       = FUNC_PLACE;
	logic [CLS_W-1:0]     item_class = '0;
	logic [CPU_W-1:0]     cpu_need   = '0;
	logic [MEM_W-1:0]     mem_need   = '0;
	logic                 busy;
	logic                 done;
	logic [2:0]           status;
	logic [BIN_W-1:0]     bin_index;
	logic [CNT_W-1:0]     bins_used;

	// Shadow copy of the bin table and the capacity registers.
	logic [CPU_W-1:0] cpu_left [NUM_CLASSES][MAX_BINS];
	logic [MEM_W-1:0] mem_left [NUM_CLASSES][MAX_BINS];
	int unsigned      open_bins [NUM_CLASSES];
	logic [CPU_W-1:0] cap_cpu [2];
	logic [MEM_W-1:0] cap_mem [2];

	pack_result_t placement_q[$];
	int           mismatch_count = 0;
	int           quiet_cycles   = 0;
	int           sender_idle_pct = 0;
	int           demand_div      = 1;
	int           clear_pct       = 1;

	first_fit_two_resource_packing_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.item_class (item_class),
		.cpu_need   (cpu_need),
		.mem_need   (mem_need),
		.done       (done),
		.status     (status),
		.bin_index  (bin_index),
		.bins_used  (bins_used)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the result word of one request and updates the shadow table.
	function automatic pack_result_t predict_placement(input logic f,
			input logic [CLS_W-1:0] cls, input logic [CPU_W-1:0] cpu,
			input logic [MEM_W-1:0] mem);
		pack_result_t r;
		int unsigned  cnt;
		r.status = ST_FULL;
		r.bin    = '0;
		r.used   = '0;
		// A class without bins answers with no change at all.
		if (int'(cls) >= NUM_CLASSES) begin
			if (f == FUNC_CLEAR)
				r.status = ST_CLEARED;
			return r;
		end
		if (f == FUNC_CLEAR) begin
			open_bins[cls] = 0;
			r.status = ST_CLEARED;
			return r;
		end
		cnt = (open_bins[cls] > MAX_BINS) ? MAX_BINS : open_bins[cls];
		r.used = CNT_W'(cnt);
		if (cpu > cap_cpu[cls] || mem > cap_mem[cls]) begin
			r.status = ST_OVERSIZE;
			return r;
		end
		// Lowest open bin that covers both demands wins.
		for (int b = 0; b < int'(cnt); b++) begin
			if (cpu_left[cls][b] >= cpu && mem_left[cls][b] >= mem) begin
				cpu_left[cls][b] = cpu_left[cls][b] - cpu;
				mem_left[cls][b] = mem_left[cls][b] - mem;
				r.status = ST_OPEN;
				r.bin    = BIN_W'(b);
				return r;
			end
		end
		if (cnt >= MAX_BINS)
			return r;
		// Open a new bin at the tail of the row.
		cpu_left[cls][cnt] = cap_cpu[cls] - cpu;
		mem_left[cls][cnt] = cap_mem[cls] - mem;
		open_bins[cls] = cnt + 1;
		r.status = ST_NEW;
		r.bin    = BIN_W'(cnt);
		r.used   = CNT_W'(cnt + 1);
		return r;
	endfunction

	// Sends one request word; called and returning at a falling edge.
	task automatic send_word(input logic f, input logic [CLS_W-1:0] cls,
			input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		func       <= f;
		item_class <= cls;
		cpu_need   <= cpu;
		mem_need   <= mem;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		placement_q.push_back(predict_placement(f, cls, cpu, mem));
		@(negedge clk);
	endtask

	// Waits until every predicted word has come back and the block is idle.
	task automatic drain;
		start <= 1'b0;
		while (placement_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAP_CPU0: cap_cpu[0] = data[CPU_W-1:0];
			REG_CAP_MEM0: cap_mem[0] = data;
			REG_CAP_CPU1: cap_cpu[1] = data[CPU_W-1:0];
			REG_CAP_MEM1: cap_mem[1] = data;
			default: ;
		endcase
	endtask

	task automatic set_capacities(input logic [CFG_DAT_W-1:0] cpu0,
			input logic [CFG_DAT_W-1:0] mem0, input logic [CFG_DAT_W-1:0] cpu1,
			input logic [CFG_DAT_W-1:0] mem1);
		drain();
		write_reg(REG_CAP_CPU0, cpu0);
		write_reg(REG_CAP_MEM0, mem0);
		write_reg(REG_CAP_CPU1, cpu1);
		write_reg(REG_CAP_MEM1, mem1);
	endtask

	// Picks a capacity pair: defaults, maxima, tiny or anything.
	task automatic draw_capacity(output logic [CFG_DAT_W-1:0] c,
			output logic [CFG_DAT_W-1:0] m);
		case ($urandom_range(3))
			0: begin c = 64; m = 256; end
			1: begin c = 1023; m = 65535; end
			2: begin
				c = CFG_DAT_W'($urandom_range(0, 15));
				m = CFG_DAT_W'($urandom_range(0, 63));
			end
			default: begin
				c = CFG_DAT_W'($urandom_range(0, 1023));
				m = CFG_DAT_W'($urandom_range(0, 65535));
			end
		endcase
	endtask

	task automatic random_capacities;
		logic [CFG_DAT_W-1:0] c0, m0, c1, m1;
		draw_capacity(c0, m0);
		draw_capacity(c1, m1);
		set_capacities(c0, m0, c1, m1);
	endtask

	// Mostly fitting demands, some oversize, some anything at all.
	task automatic send_random_word;
		logic             f;
		logic [CLS_W-1:0] cls;
		logic [CPU_W-1:0] cpu;
		logic [MEM_W-1:0] mem;
		int               r;
		int               cc;
		int               cm;
		f   = ($urandom_range(99) < clear_pct) ? FUNC_CLEAR : FUNC_PLACE;
		cls = CLS_W'($urandom_range(1));
		cc  = int'(cap_cpu[cls]);
		cm  = int'(cap_mem[cls]);
		r   = $urandom_range(99);
		if (r < 75) begin
			cpu = CPU_W'($urandom_range(0, cc / demand_div));
			mem = MEM_W'($urandom_range(0, cm / demand_div));
		end else if (r < 88) begin
			cpu = CPU_W'($urandom_range(0, cc));
			mem = MEM_W'($urandom_range(0, cm));
			if ($urandom_range(1) && cc < 1023)
				cpu = CPU_W'($urandom_range(cc + 1, 1023));
			else if (cm < 65535)
				mem = MEM_W'($urandom_range(cm + 1, 65535));
		end else begin
			cpu = CPU_W'($urandom);
			mem = MEM_W'($urandom);
		end
		send_word(f, cls, cpu, mem);
	endtask

	// Compare each result word with the oldest prediction.
	always @(posedge clk) begin
		pack_result_t exp_word;
		if (arst_n && done === 1'b1) begin
			if (placement_q.size() == 0) begin
				$display("%0t: unexpected word status %0d bin %0d used %0d",
					$time, status, bin_index, bins_used);
				mismatch_count++;
			end else begin
				exp_word = placement_q.pop_front();
				if (status !== exp_word.status || bin_index !== exp_word.bin ||
						bins_used !== exp_word.used) begin
					$display("%0t: expected status %0d bin %0d used %0d, got %0d %0d %0d",
						$time, exp_word.status, exp_word.bin, exp_word.used,
						status, bin_index, bins_used);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Corner cases at the default capacities, then after capacity changes.
	task automatic test_directed;
		sender_idle_pct = 0;
		send_word(FUNC_PLACE, 0, 0, 0);
		send_word(FUNC_PLACE, 0, 64, 256);
		send_word(FUNC_PLACE, 0, 1, 0);
		send_word(FUNC_PLACE, 0, 0, 256);
		send_word(FUNC_PLACE, 0, 65, 0);
		send_word(FUNC_PLACE, 0, 0, 257);
		send_word(FUNC_PLACE, 0, 1023, 65535);
		send_word(FUNC_PLACE, 0, 63, 0);
		send_word(FUNC_CLEAR, 1, 1023, 65535);
		send_word(FUNC_PLACE, 1, 32, 128);
		send_word(FUNC_PLACE, 1, 32, 128);
		send_word(FUNC_PLACE, 1, 33, 1);
		send_word(FUNC_CLEAR, 0, 1023, 65535);
		send_word(FUNC_PLACE, 0, 10, 10);
		// Larger capacity leaves the open bin alone; upper data bits are dropped.
		set_capacities(16'hFFFF, 16'hFFFF, 64, 256);
		send_word(FUNC_PLACE, 0, 100, 10);
		send_word(FUNC_PLACE, 0, 54, 0);
		send_word(FUNC_PLACE, 0, 1023, 65535);
		// Zero capacity: only zero demands fit.
		set_capacities(16'hFFFF, 16'hFFFF, 0, 0);
		send_word(FUNC_CLEAR, 1, 0, 0);
		send_word(FUNC_PLACE, 1, 0, 0);
		send_word(FUNC_PLACE, 1, 0, 0);
		send_word(FUNC_PLACE, 1, 1, 0);
		send_word(FUNC_PLACE, 1, 0, 1);
	endtask

	// Fill all bins of one class, then ask for one more.
	task automatic test_full_table;
		set_capacities(1, 1, 64, 256);
		send_word(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < MAX_BINS; i++)
			send_word(FUNC_PLACE, 0, 1, 1);
		send_word(FUNC_PLACE, 0, 1, 1);
		send_word(FUNC_PLACE, 0, 0, 0);
		send_word(FUNC_PLACE, 0, 2, 0);
		send_word(FUNC_CLEAR, 0, 0, 0);
	endtask

	// Random words; capacities change halfway while bins stay open.
	task automatic test_random_phase(input int items, input int idle_pct);
		sender_idle_pct = idle_pct;
		random_capacities();
		demand_div = ($urandom_range(1)) ? 1 : $urandom_range(2, 8);
		clear_pct  = $urandom_range(1, 3);
		for (int i = 0; i < items / 2; i++)
			send_random_word();
		random_capacities();
		for (int i = items / 2; i < items; i++)
			send_random_word();
	endtask

	initial begin
		for (int c = 0; c < NUM_CLASSES; c++)
			open_bins[c] = 0;
		cap_cpu = '{64, 64};
		cap_mem = '{256, 256};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_random_phase(600, 0);
		test_random_phase(500, 71);
		test_random_phase(450, 0);
		test_random_phase(450, 9);
		drain();
		repeat (MAX_BINS + 8) @(posedge clk);
		if (mismatch_count == 0 && placement_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
